/* design/apfp_pkg.sv */
// shared types and constants for the command frame parser
package apfp_pkg;

  localparam int unsigned COUNT_W = 17;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [COUNT_W-1:0] POS_LEN1 = 17'd4;
  localparam logic [COUNT_W-1:0] POS_XLHI = 17'd5;
  localparam logic [COUNT_W-1:0] POS_XLLO = 17'd6;

  localparam logic [COUNT_W-1:0] LEN_HEADER = 17'd4;
  localparam logic [COUNT_W-1:0] LEN_SHORT_LE = 17'd5;
  localparam logic [COUNT_W-1:0] LEN_EXT_HDR = 17'd7;
  localparam logic [COUNT_W-1:0] ADD_SHORT_LC = 17'd5;
  localparam logic [COUNT_W-1:0] ADD_SHORT_LCLE = 17'd6;
  localparam logic [COUNT_W-1:0] ADD_EXT_LC = 17'd7;
  localparam logic [COUNT_W-1:0] ADD_EXT_LCLE = 17'd9;

  localparam logic [2:0] OFF_NONE = 3'd0;
  localparam logic [2:0] OFF_SHORT = 3'd5;
  localparam logic [2:0] OFF_EXT = 3'd7;

  localparam logic [7:0] BYTE_ZERO = 8'h00;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_BAD   = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    status_e     parse_status;
    logic [7:0]  class_byte;
    logic [7:0]  instruction;
    logic [7:0]  param_one;
    logic [7:0]  param_two;
    logic [15:0] command_length;
    logic [15:0] expected_length;
    logic        has_expected;
    logic        is_extended;
    logic [2:0]  data_offset;
  } out_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0] byte_count;
    logic [3:0][7:0]    header_store;
    logic [7:0]         first_length_byte;
    logic [15:0]        extended_length_value;
    logic [7:0]         previous_byte;
  } parse_state_t;

endpackage

/* design/apfp_if.sv */
// valid/ready channel interfaces for input bytes and parse results
interface apdu_in_if;
  logic               valid;
  logic               ready;
  apfp_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface apdu_out_if;
  logic                valid;
  logic                ready;
  apfp_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/apfp_classify.sv */
// state update and frame classification for one byte
module apfp_classify (
  input  apfp_pkg::parse_state_t state_i,
  input  apfp_pkg::in_word_t     word_i,
  output apfp_pkg::parse_state_t state_o,
  output apfp_pkg::out_word_t    result_o
);

  logic [apfp_pkg::COUNT_W-1:0] pos;
  logic [apfp_pkg::COUNT_W-1:0] len;
  logic [apfp_pkg::COUNT_W-1:0] b1;
  logic [apfp_pkg::COUNT_W-1:0] xl;
  logic [7:0]                   b;

  always_comb begin
    pos = state_i.byte_count;
    b = word_i.frame_byte;
    state_o = state_i;
    if (pos < apfp_pkg::LEN_HEADER) begin
      state_o.header_store[pos[1:0]] = b;
    end else if (pos == apfp_pkg::POS_LEN1) begin
      state_o.first_length_byte = b;
    end else if (pos == apfp_pkg::POS_XLHI) begin
      state_o.extended_length_value = {b, apfp_pkg::BYTE_ZERO};
    end else if (pos == apfp_pkg::POS_XLLO) begin
      state_o.extended_length_value = {state_i.extended_length_value[15:8], b};
    end
    state_o.previous_byte = b;
    if (pos != apfp_pkg::COUNT_MAX) begin
      state_o.byte_count = pos + 17'd1;
    end
  end

  always_comb begin
    len = state_o.byte_count;
    b1 = {9'd0, state_o.first_length_byte};
    xl = {1'b0, state_o.extended_length_value};

    result_o = '0;
    result_o.parse_status = apfp_pkg::ST_OK;
    result_o.class_byte = state_o.header_store[0];
    result_o.instruction = state_o.header_store[1];
    result_o.param_one = state_o.header_store[2];
    result_o.param_two = state_o.header_store[3];

    if (len < apfp_pkg::LEN_HEADER) begin
      result_o.parse_status = apfp_pkg::ST_SHORT;
      result_o.class_byte = '0;
      result_o.instruction = '0;
      result_o.param_one = '0;
      result_o.param_two = '0;
    end else if (len == apfp_pkg::LEN_HEADER) begin
      result_o.parse_status = apfp_pkg::ST_OK;
    end else if (len == apfp_pkg::LEN_SHORT_LE) begin
      result_o.expected_length = {8'd0, state_o.first_length_byte};
      result_o.has_expected = 1'b1;
    end else if (state_o.first_length_byte != apfp_pkg::BYTE_ZERO) begin
      if (len == b1 + apfp_pkg::ADD_SHORT_LC) begin
        result_o.command_length = {8'd0, state_o.first_length_byte};
        result_o.data_offset = apfp_pkg::OFF_SHORT;
      end else if (len == b1 + apfp_pkg::ADD_SHORT_LCLE) begin
        result_o.command_length = {8'd0, state_o.first_length_byte};
        result_o.expected_length = {8'd0, b};
        result_o.has_expected = 1'b1;
        result_o.data_offset = apfp_pkg::OFF_SHORT;
      end else begin
        result_o.parse_status = apfp_pkg::ST_BAD;
      end
    end else if (len < apfp_pkg::LEN_EXT_HDR) begin
      result_o.parse_status = apfp_pkg::ST_BAD;
    end else if (len == apfp_pkg::LEN_EXT_HDR) begin
      result_o.expected_length = state_o.extended_length_value;
      result_o.has_expected = 1'b1;
      result_o.is_extended = 1'b1;
    end else if (state_o.extended_length_value == 16'd0) begin
      result_o.parse_status = apfp_pkg::ST_BAD;
    end else if (len == xl + apfp_pkg::ADD_EXT_LC) begin
      result_o.command_length = state_o.extended_length_value;
      result_o.is_extended = 1'b1;
      result_o.data_offset = apfp_pkg::OFF_EXT;
    end else if (len == xl + apfp_pkg::ADD_EXT_LCLE) begin
      result_o.command_length = state_o.extended_length_value;
      result_o.expected_length = {state_i.previous_byte, b};
      result_o.has_expected = 1'b1;
      result_o.is_extended = 1'b1;
      result_o.data_offset = apfp_pkg::OFF_EXT;
    end else begin
      result_o.parse_status = apfp_pkg::ST_BAD;
    end

    if (result_o.parse_status == apfp_pkg::ST_BAD) begin
      result_o.command_length = '0;
      result_o.expected_length = '0;
      result_o.has_expected = 1'b0;
      result_o.is_extended = 1'b0;
      result_o.data_offset = apfp_pkg::OFF_NONE;
    end
  end

endmodule

/* design/apdu_frame_parser.sv */
// top level of the command frame parser
//
// in_i carries one frame byte per word with a last-byte flag; out_o carries
// one result word per frame, produced on the last byte. Both are valid/ready
// channels, a word moves on a rising edge with valid and ready high.
// A byte word is captured in an input register; when it leaves that register
// the classifier updates the frame state and, on a last byte, writes the result
// register.
// Throughput is one byte per cycle while no last byte waits on a stalled result,
// set by the single classify step between the input and result registers; a new
// frame may start right after a last byte with no gap.
// Reset clears the byte count, header and length registers and both valid
// flags. When the receiver stalls, the result is held; non-last bytes keep
// flowing through the state, and a last byte waits in the input register
// until the result register frees, which then backs up in_i.ready.
module apdu_frame_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  apdu_in_if.sink            in_i,
  apdu_out_if.source         out_o
);

  logic                   s1_valid_q;
  apfp_pkg::in_word_t     s1_word_q;
  logic                   out_valid_q;
  logic                   out_valid_d;
  apfp_pkg::out_word_t    out_word_q;
  apfp_pkg::parse_state_t state_q;
  apfp_pkg::parse_state_t state_d;
  apfp_pkg::parse_state_t state_upd;
  apfp_pkg::out_word_t    result;
  logic                   out_free;
  logic                   s1_fire;
  logic                   in_fire;

  apfp_classify u_classify (
    .state_i  (state_q),
    .word_i   (s1_word_q),
    .state_o  (state_upd),
    .result_o (result)
  );

  assign out_free = !out_valid_q || out_o.ready;
  assign s1_fire = s1_valid_q && (!s1_word_q.last_byte || out_free);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire = in_i.valid && in_i.ready;

  assign out_o.valid = out_valid_q;
  assign out_o.data = out_word_q;

  always_comb begin
    state_d = state_q;
    if (s1_fire) begin
      state_d = s1_word_q.last_byte ? '0 : state_upd;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && s1_word_q.last_byte) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      state_q <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      out_valid_q <= out_valid_d;
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_word_q <= in_i.data;
    end
    if (s1_fire && s1_word_q.last_byte) begin
      out_word_q <= result;
    end
  end

endmodule

/* design/apfp_checker.sv */
// port-level assertions for the command frame parser and their bind
module apfp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input apfp_pkg::out_word_t out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result word changed while stalled");

  a_short_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.parse_status == apfp_pkg::ST_SHORT |->
      out_data_i.class_byte == 8'd0 && out_data_i.instruction == 8'd0 &&
      out_data_i.param_one == 8'd0 && out_data_i.param_two == 8'd0 &&
      out_data_i.command_length == 16'd0 && !out_data_i.has_expected)
    else $error("too short frame carries fields");

  a_bad_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.parse_status == apfp_pkg::ST_BAD |->
      out_data_i.command_length == 16'd0 && out_data_i.expected_length == 16'd0 &&
      !out_data_i.has_expected && !out_data_i.is_extended &&
      out_data_i.data_offset == apfp_pkg::OFF_NONE)
    else $error("malformed frame carries length fields");

  a_offset_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      (out_data_i.data_offset == apfp_pkg::OFF_NONE &&
        out_data_i.command_length == 16'd0) ||
      (out_data_i.data_offset == apfp_pkg::OFF_SHORT && !out_data_i.is_extended &&
        out_data_i.command_length != 16'd0) ||
      (out_data_i.data_offset == apfp_pkg::OFF_EXT && out_data_i.is_extended &&
        out_data_i.command_length != 16'd0))
    else $error("data offset disagrees with length form");

endmodule

bind apdu_frame_parser apfp_checker u_apfp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
